// ===== design/xcfp_pkg.sv =====
package xcfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned STATUS_W = 3;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_HEADER_SECOND = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_HEADER_THIRD  = 2'd2;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h20;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h21;
  localparam logic [BYTE_W-1:0] HEADER_THIRD_RST  = 8'h22;

  localparam logic [BYTE_W-1:0] END_MARK   = 8'h00;
  localparam logic [BYTE_W-1:0] LEN_SHORT  = 8'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED = 3'd0,
    ST_HEADER  = 3'd1,
    ST_LENGTH  = 3'd2,
    ST_BODY    = 3'd3,
    ST_GOOD    = 3'd4,
    ST_BAD     = 3'd5,
    ST_OVERRUN = 3'd6
  } status_t;

  typedef struct packed {
    logic              in_frame;
    logic              have_length;
    logic [BYTE_W-1:0] byte_count;
    logic [BYTE_W-1:0] declared_length;
    logic [BYTE_W-1:0] running_check;
    logic [BYTE_W-1:0] current_code;
    logic              check_match;
  } parse_state_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] frame_total;
    logic [BYTE_W-1:0] frame_code;
    logic [BYTE_W-1:0] byte_position;
    logic [BYTE_W-1:0] echo_byte;
  } parse_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
  } header_cfg_t;

endpackage

// ===== design/xcfp_step.sv =====
module xcfp_step (
  input  xcfp_pkg::parse_state_t            cur,
  input  xcfp_pkg::header_cfg_t             hdr,
  input  logic [xcfp_pkg::BYTE_W-1:0]       rx_byte,
  output xcfp_pkg::parse_state_t            nxt,
  output xcfp_pkg::parse_result_t           res
);

  logic                          hdr_hit;
  logic [xcfp_pkg::BYTE_W-1:0]   pos;
  logic [xcfp_pkg::BYTE_W:0]     pos_w;
  logic [xcfp_pkg::BYTE_W:0]     len_w;
  logic [xcfp_pkg::BYTE_W-1:0]   len_check;
  logic [xcfp_pkg::BYTE_W-1:0]   body_check;

  assign hdr_hit = (rx_byte == hdr.first) || (rx_byte == hdr.second) ||
                   (rx_byte == hdr.third);
  assign pos     = cur.byte_count + 8'd1;
  assign pos_w   = {1'b0, pos};
  assign len_w   = {1'b0, cur.declared_length};
  assign len_check  = cur.running_check ^ rx_byte;
  // fold the byte in only while it lies before the checksum byte
  assign body_check = ((pos_w + 9'd2) <= len_w) ? len_check : cur.running_check;

  always_comb begin
    nxt               = cur;
    res.echo_byte     = rx_byte;
    res.byte_position = '0;
    res.frame_code    = '0;
    res.frame_total   = '0;
    res.status        = xcfp_pkg::ST_IGNORED;

    if (!cur.in_frame) begin
      if (hdr_hit) begin
        nxt.in_frame      = 1'b1;
        nxt.have_length   = 1'b0;
        nxt.byte_count    = 8'd1;
        nxt.running_check = rx_byte;
        nxt.current_code  = rx_byte;
        nxt.check_match   = 1'b0;
        res.byte_position = 8'd1;
        res.frame_code    = rx_byte;
        res.status        = xcfp_pkg::ST_HEADER;
      end
    end else if (!cur.have_length) begin
      nxt.have_length     = 1'b1;
      nxt.byte_count      = 8'd2;
      nxt.declared_length = rx_byte;
      nxt.running_check   = len_check;
      // three-byte frame: the length byte is the checked byte, uninverted
      if (rx_byte == xcfp_pkg::LEN_SHORT) begin
        nxt.check_match = (rx_byte == len_check);
      end
      res.byte_position = 8'd2;
      res.frame_code    = cur.current_code;
      res.frame_total   = rx_byte;
      res.status        = xcfp_pkg::ST_LENGTH;
    end else begin
      nxt.byte_count    = pos;
      nxt.running_check = body_check;
      if ((pos_w + 9'd1) == len_w) begin
        nxt.running_check = ~body_check;
        nxt.check_match   = (rx_byte == ~body_check);
      end
      res.byte_position = pos;
      res.frame_code    = cur.current_code;
      res.frame_total   = cur.declared_length;
      res.status        = xcfp_pkg::ST_BODY;
      if (pos_w >= len_w) begin
        nxt.in_frame    = 1'b0;
        nxt.have_length = 1'b1;
        nxt.byte_count  = '0;
        if (pos_w == len_w) begin
          res.status = (cur.check_match && (rx_byte == xcfp_pkg::END_MARK)) ?
                       xcfp_pkg::ST_GOOD : xcfp_pkg::ST_BAD;
        end else begin
          res.status = xcfp_pkg::ST_OVERRUN;
        end
      end
    end
  end

endmodule

// ===== design/xor_checksum_frame_parser_unit.sv =====
// XOR-checksum serial frame parser.
//
// Input stream (in_*): one received byte per transaction in in_tdata.
// Result stream (out_*): exactly one result per input byte, in order:
//   out_tdata = echo byte, position in frame, frame code, declared length;
//   out_tuser = status (ignored, header, length, body, good, bad, overrun).
// Config port (cfg_*): write the three accepted header bytes by index while
// the parser is idle; index 3 is ignored.
//
// An accepted byte is loaded into the input register, and its result is then
// registered in the output register.
// Throughput: one byte per cycle while out_tready holds; the frame state is
// updated by one short compare/XOR step between the input and output registers.
// The input register keeps taking a byte while a result waits on a stalled
// receiver; once both registers are full, in_tready drops until out_tready.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to idle and restores header bytes 0x20, 0x21, 0x22.
module xor_checksum_frame_parser_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] echo_byte, [15:8] byte_position, [23:16] frame_code, [31:24] frame_total
  output logic [31:0]                      out_tdata,
  output logic [2:0]                       out_tuser,  // [2:0] status
  // configuration writes
  input  logic                             cfg_wr_en,
  input  logic [xcfp_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [xcfp_pkg::BYTE_W-1:0]      cfg_wdata
);

  xcfp_pkg::header_cfg_t          hdr_r;
  xcfp_pkg::parse_state_t         state_r;
  xcfp_pkg::parse_state_t         state_nxt;
  xcfp_pkg::parse_result_t        res_nxt;
  xcfp_pkg::parse_result_t        res_r;

  logic                           in_valid_r;
  logic [xcfp_pkg::BYTE_W-1:0]    in_byte_r;
  logic                           out_valid_r;
  logic                           advance;

  // advance the input register into the output register when it is free
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  // header registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r.first  <= xcfp_pkg::HEADER_FIRST_RST;
      hdr_r.second <= xcfp_pkg::HEADER_SECOND_RST;
      hdr_r.third  <= xcfp_pkg::HEADER_THIRD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        xcfp_pkg::CFG_HEADER_FIRST:  hdr_r.first  <= cfg_wdata;
        xcfp_pkg::CFG_HEADER_SECOND: hdr_r.second <= cfg_wdata;
        xcfp_pkg::CFG_HEADER_THIRD:  hdr_r.third  <= cfg_wdata;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  xcfp_step u_step (
    .cur     (state_r),
    .hdr     (hdr_r),
    .rx_byte (in_byte_r),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  // frame state and output valid: commit only when a byte moves forward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  // result payload, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.frame_total, res_r.frame_code,
                       res_r.byte_position, res_r.echo_byte};
  assign out_tuser  = res_r.status;

endmodule

// ===== design/xcfp_checker.sv =====
module xcfp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [31:0]                  out_tdata,
  input logic [2:0]                   out_tuser
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // ignored bytes carry no frame context
  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == xcfp_pkg::ST_IGNORED) |->
      (out_tdata[31:8] == 24'd0))
    else $error("ignored byte with frame fields");

  // a header opens a frame at position one with its own code
  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == xcfp_pkg::ST_HEADER) |->
      (out_tdata[15:8] == 8'd1) && (out_tdata[23:16] == out_tdata[7:0]) &&
      (out_tdata[31:24] == 8'd0))
    else $error("header result malformed");

  // the length byte is position two and declares the total
  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == xcfp_pkg::ST_LENGTH) |->
      (out_tdata[15:8] == 8'd2) && (out_tdata[31:24] == out_tdata[7:0]))
    else $error("length result malformed");

endmodule

bind xor_checksum_frame_parser_unit xcfp_checker u_xcfp_checker (.*);
